/* hdl/qhp_pkg.sv */
// Shared types and constants for the quantizer and bit packer.
package qhp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int FILL_W     = 5;
    localparam int USED_W     = 6;
    localparam int CODES_W    = 15;
    localparam int LENS_W     = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [2:0] {
        REG_EDGE_FIRST   = 3'd0,
        REG_EDGE_SECOND  = 3'd1,
        REG_EDGE_THIRD   = 3'd2,
        REG_EDGE_FOURTH  = 3'd3,
        REG_CODE_WORDS   = 3'd4,
        REG_CODE_LENGTHS = 3'd5
    } reg_index_t;

    localparam logic signed [WORD_BITS-1:0] EDGE_FIRST_RST  = -32'sd131072;
    localparam logic signed [WORD_BITS-1:0] EDGE_SECOND_RST = -32'sd65536;
    localparam logic signed [WORD_BITS-1:0] EDGE_THIRD_RST  = 32'sd65536;
    localparam logic signed [WORD_BITS-1:0] EDGE_FOURTH_RST = 32'sd131072;
    localparam logic [CODES_W-1:0] CODE_WORDS_RST   = 15'd29707;
    localparam logic [LENS_W-1:0]  CODE_LENGTHS_RST = 10'd939;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] edge_first;
        logic signed [WORD_BITS-1:0] edge_second;
        logic signed [WORD_BITS-1:0] edge_third;
        logic signed [WORD_BITS-1:0] edge_fourth;
        logic [CODES_W-1:0]          code_words;
        logic [LENS_W-1:0]           code_lengths;
    } cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [USED_W-1:0]    used;
        logic                 frame_end;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } pack_out_t;

endpackage

/* hdl/qhp_packer.sv */
// Quantizer and LSB-first code packer with accumulator state.
module qhp_packer
    import qhp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  logic signed [WORD_BITS-1:0] sample,
    input  logic                        final_sample,
    input  logic                        advance,
    output pack_out_t                   result
);

    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    always_comb
    begin
        logic [2:0]           sym;
        logic [1:0]           len;
        logic [2:0]           code;
        logic [2:0]           mask;
        logic [USED_W-1:0]    total;
        logic [1:0]           rem;
        logic [WORD_BITS-1:0] acc_or;
        logic [WORD_BITS-1:0] acc_mid;
        logic [FILL_W-1:0]    fill_mid;

        sym = 3'(sample >= cfg.edge_first) + 3'(sample >= cfg.edge_second)
            + 3'(sample >= cfg.edge_third) + 3'(sample >= cfg.edge_fourth);

        case (sym)
            3'd0:    begin len = cfg.code_lengths[1:0]; code = cfg.code_words[2:0];   end
            3'd1:    begin len = cfg.code_lengths[3:2]; code = cfg.code_words[5:3];   end
            3'd2:    begin len = cfg.code_lengths[5:4]; code = cfg.code_words[8:6];   end
            3'd3:    begin len = cfg.code_lengths[7:6]; code = cfg.code_words[11:9];  end
            default: begin len = cfg.code_lengths[9:8]; code = cfg.code_words[14:12]; end
        endcase

        case (len)
            2'd0:    mask = 3'b000;
            2'd1:    mask = 3'b001;
            2'd2:    mask = 3'b011;
            default: mask = 3'b111;
        endcase
        code = code & mask;

        total  = USED_W'(fill_reg) + USED_W'(len);
        acc_or = acc_reg | (WORD_BITS'(code) << fill_reg);
        rem    = total[1:0];

        result = '0;

        if (total >= USED_W'(WORD_BITS))
        begin
            // word full: emit it, spill-over bits start the next word
            result.count           = 2'd1;
            result.first.word      = acc_or;
            result.first.used      = USED_W'(WORD_BITS);
            result.first.frame_end = final_sample && (rem == 2'd0);
            acc_mid  = (rem != 2'd0) ? WORD_BITS'(code >> (len - rem)) : '0;
            fill_mid = FILL_W'(rem);
        end
        else
        begin
            acc_mid  = acc_or;
            fill_mid = total[FILL_W-1:0];
        end

        acc_next  = acc_mid;
        fill_next = fill_mid;

        if (final_sample)
        begin
            if (fill_mid != '0)
            begin
                if (result.count == 2'd0)
                begin
                    result.first.word      = acc_mid;
                    result.first.used      = USED_W'(fill_mid);
                    result.first.frame_end = 1'b1;
                end
                else
                begin
                    result.second.word      = acc_mid;
                    result.second.used      = USED_W'(fill_mid);
                    result.second.frame_end = 1'b1;
                end
                result.count = result.count + 2'd1;
            end
            else if (result.count == 2'd0)
            begin
                // empty frame end marker
                result.count           = 2'd1;
                result.first.frame_end = 1'b1;
            end
            acc_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

endmodule

/* hdl/quantize_and_huffman_pack.sv */
// Top level: config registers, input register, packer and output queue.
// An accepted input is registered; the packer then writes its words into the output queue.
// Throughput: one sample per cycle unless stalled; one word leaves per cycle while out_ready
// is high; a sample may yield two words; input stalls while the 4-entry queue holds 3 or more.
// Reset clears the packer state and the queue and restores the default edges
// and code tables.
module quantize_and_huffman_pack
    import qhp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [WORD_BITS-1:0]  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [31:0]    sample,
    input  logic                  final_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           packed_word,
    output logic [5:0]            used_bits,
    output logic                  frame_end
);

    cfg_t                        cfg_reg;
    logic                        in_valid_reg;
    logic signed [WORD_BITS-1:0] sample_reg;
    logic                        final_reg;
    logic                        advance;
    logic                        pop;
    pack_out_t                   pack_res;

    res_t                        fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]          wr_ptr_reg;
    logic [FIFO_AW-1:0]          wr_ptr_next;
    logic [FIFO_AW-1:0]          rd_ptr_reg;
    logic [FIFO_AW-1:0]          rd_ptr_next;
    logic [FIFO_CW-1:0]          count_reg;
    logic [FIFO_CW-1:0]          count_next;
    logic [1:0]                  push_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_first   <= EDGE_FIRST_RST;
            cfg_reg.edge_second  <= EDGE_SECOND_RST;
            cfg_reg.edge_third   <= EDGE_THIRD_RST;
            cfg_reg.edge_fourth  <= EDGE_FOURTH_RST;
            cfg_reg.code_words   <= CODE_WORDS_RST;
            cfg_reg.code_lengths <= CODE_LENGTHS_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_EDGE_FIRST:   cfg_reg.edge_first   <= cfg_data;
                REG_EDGE_SECOND:  cfg_reg.edge_second  <= cfg_data;
                REG_EDGE_THIRD:   cfg_reg.edge_third   <= cfg_data;
                REG_EDGE_FOURTH:  cfg_reg.edge_fourth  <= cfg_data;
                REG_CODE_WORDS:   cfg_reg.code_words   <= cfg_data[CODES_W-1:0];
                REG_CODE_LENGTHS: cfg_reg.code_lengths <= cfg_data[LENS_W-1:0];
                default:          ;
            endcase
        end
    end

    // the input stage moves on only when the queue can take two words
    assign advance  = in_valid_reg && (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= sample;
            final_reg  <= final_sample;
        end
    end

    qhp_packer u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample       (sample_reg),
        .final_sample (final_reg),
        .advance      (advance),
        .result       (pack_res)
    );

    assign push_n      = advance ? pack_res.count : 2'd0;
    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && out_ready;
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
    assign count_next  = count_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= pack_res.first;
        if (push_n == 2'd2)
            fifo_reg[FIFO_AW'(wr_ptr_reg + 1'b1)] <= pack_res.second;
    end

    assign packed_word = fifo_reg[rd_ptr_reg].word;
    assign used_bits   = fifo_reg[rd_ptr_reg].used;
    assign frame_end   = fifo_reg[rd_ptr_reg].frame_end;

endmodule
